// ===== design/tlca_pkg.sv =====
// Package for the tree LCA distance query engine.
// Field widths, the ancestor "none" code, saturation limits, opcodes and the sequencer states.
// No dependencies.
`default_nettype none

package tlca_pkg;

  localparam int ID_W    = 10;
  localparam int WGT_W   = 32;
  localparam int DEPTH_W = 10;
  localparam int DIST_W  = 42;
  localparam int PATH_W  = 43;
  localparam int ANC_W   = ID_W + 1;
  localparam int INFO_W  = DEPTH_W + DIST_W;

  localparam int DEF_MAX_NODES   = 1024;
  localparam int DEF_LIFT_LEVELS = 10;

  localparam logic [ANC_W-1:0]   ANC_NONE  = '1;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [13:0] {
    S_IDLE        = 14'b00000000000001,
    S_LD_ROOT     = 14'b00000000000010,
    S_LD_PAR      = 14'b00000000000100,
    S_LD_CHAIN    = 14'b00000000001000,
    S_Q_A         = 14'b00000000010000,
    S_Q_B         = 14'b00000000100000,
    S_Q_SORT      = 14'b00000001000000,
    S_Q_LIFT      = 14'b00000010000000,
    S_Q_LIFT_END  = 14'b00000100000000,
    S_Q_CLIMB     = 14'b00001000000000,
    S_Q_CLIMB_END = 14'b00010000000000,
    S_Q_LCA       = 14'b00100000000000,
    S_Q_INFO      = 14'b01000000000000,
    S_Q_OUT       = 14'b10000000000000
  } state_t;

endpackage

`default_nettype wire

// ===== design/tree_lca_distance_query_top.sv =====
// Binary-lifting tree engine: node loads build depth, root distance and ancestor rows;
// queries return the lowest common ancestor and the weighted path distance.
// Depends on tlca_pkg.
// Load of a root or of a child: one ancestor-table level per cycle, with one
// ancestor-table read per level on the chained read port for a child.
// Query: the lift, then the top-down climb, one table level per cycle. One item at a time.
// Out-of-range loads and queries are accepted and dropped.
// Reset clears the sequencer and the output valid; the memories hold whatever was written.
`default_nettype none

module tree_lca_distance_query_top #(
  parameter int MAX_NODES   = tlca_pkg::DEF_MAX_NODES,
  parameter int LIFT_LEVELS = tlca_pkg::DEF_LIFT_LEVELS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic [tlca_pkg::ID_W-1:0]    in_node_id,
  input  logic [tlca_pkg::ID_W-1:0]    in_parent_id,
  input  logic                         in_is_root,
  input  logic [tlca_pkg::WGT_W-1:0]   in_edge_weight,
  input  logic [tlca_pkg::ID_W-1:0]    in_query_a,
  input  logic [tlca_pkg::ID_W-1:0]    in_query_b,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tlca_pkg::ID_W-1:0]    out_ancestor_node,
  output logic [tlca_pkg::PATH_W-1:0]  out_path_distance
);

  localparam int ID_W    = tlca_pkg::ID_W;
  localparam int ANC_W   = tlca_pkg::ANC_W;
  localparam int DEPTH_W = tlca_pkg::DEPTH_W;
  localparam int DIST_W  = tlca_pkg::DIST_W;
  localparam int PATH_W  = tlca_pkg::PATH_W;
  localparam int INFO_W  = tlca_pkg::INFO_W;
  localparam int WGT_W   = tlca_pkg::WGT_W;

  localparam int ID_SPAN   = 1 << ID_W;
  localparam int NODES     = (MAX_NODES < ID_SPAN) ? MAX_NODES : ID_SPAN;
  localparam int AW        = $clog2(NODES);
  localparam int LW        = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int ANC_DEPTH = LIFT_LEVELS * (1 << AW);
  localparam int ANC_AW    = $clog2(ANC_DEPTH);

  localparam logic [LW-1:0]    LVL_LAST  = LW'(LIFT_LEVELS - 1);
  localparam logic [LW-1:0]    LVL_FIRST = LW'(1);
  localparam logic [ANC_W-1:0] NONE      = tlca_pkg::ANC_NONE;

  function automatic logic [ANC_AW-1:0] anc_addr(input logic [LW-1:0] lvl,
                                                 input logic [ID_W-1:0] node);
    anc_addr = ANC_AW'({lvl, node[AW-1:0]});
  endfunction

  logic [INFO_W-1:0] info_mem [NODES];
  logic [ANC_W-1:0]  anc_mem  [ANC_DEPTH];

  tlca_pkg::state_t state_r, state_nxt;

  logic [LW-1:0]      lvl_r, lvl_nxt;
  logic [ID_W-1:0]    c_r, c_nxt;
  logic [ID_W-1:0]    p_r, p_nxt;
  logic [WGT_W-1:0]   w_r, w_nxt;
  logic [ANC_W-1:0]   a_r, a_nxt;
  logic [ANC_W-1:0]   b_r, b_nxt;
  logic [DEPTH_W-1:0] delta_r, delta_nxt;
  logic [DEPTH_W-1:0] depth_a_r, depth_a_nxt;
  logic [DIST_W-1:0]  dist_a_r, dist_a_nxt;
  logic [PATH_W-1:0]  sum_r, sum_nxt;
  logic [ID_W-1:0]    l_r, l_nxt;
  logic               l_none_r, l_none_nxt;
  logic               pend_r, pend_nxt;
  logic               have_r, have_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]    out_anc_r, out_anc_nxt;
  logic [PATH_W-1:0]  out_dist_r, out_dist_nxt;

  logic               info_we, info_re;
  logic [AW-1:0]      info_wa, info_ra;
  logic [INFO_W-1:0]  info_wd;
  logic [INFO_W-1:0]  info_q_r;

  logic               anc_we, anc_rea, anc_reb;
  logic [ANC_AW-1:0]  anc_wa, anc_raa, anc_rab;
  logic [ANC_W-1:0]   anc_wd;
  logic [ANC_W-1:0]   anc_qa_r, anc_qb_r;
  logic               fwd_r;
  logic [ANC_W-1:0]   fwd_d_r;

  logic [ANC_W-1:0]   rd_a, rd_b;
  logic [ANC_W-1:0]   nv, bval, ua, ub, a_cl, b_cl, lca;
  logic [DEPTH_W-1:0] q_da, q_db, par_depth;
  logic [DIST_W-1:0]  q_dist_b, par_dist, info_dist;
  logic [PATH_W-1:0]  grown, sub2;
  logic               c_ok, p_ok, qa_ok, qb_ok;

  assign rd_a = fwd_r ? fwd_d_r : anc_qa_r;
  assign rd_b = anc_qb_r;

  assign nv   = pend_r ? rd_a : NONE;
  assign bval = pend_r ? rd_b : b_r;
  assign ua   = (a_r == NONE) ? NONE : rd_a;
  assign ub   = (b_r == NONE) ? NONE : rd_b;
  assign a_cl = (have_r && (ua != ub)) ? ua : a_r;
  assign b_cl = (have_r && (ua != ub)) ? ub : b_r;
  assign lca  = (a_r == NONE) ? NONE : rd_a;

  assign par_depth = info_q_r[INFO_W-1:DIST_W];
  assign par_dist  = info_q_r[DIST_W-1:0];
  assign info_dist = info_q_r[DIST_W-1:0];
  assign q_da      = depth_a_r;
  assign q_db      = info_q_r[INFO_W-1:DIST_W];
  assign q_dist_b  = info_q_r[DIST_W-1:0];
  assign grown     = {1'b0, par_dist} + {{(PATH_W-WGT_W){1'b0}}, w_r};
  assign sub2      = {info_dist, 1'b0};

  assign c_ok  = int'(in_node_id) < MAX_NODES;
  assign p_ok  = int'(in_parent_id) < MAX_NODES;
  assign qa_ok = int'(in_query_a) < MAX_NODES;
  assign qb_ok = int'(in_query_b) < MAX_NODES;

  assign in_stall          = (state_r != tlca_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_ancestor_node = out_anc_r;
  assign out_path_distance = out_dist_r;

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    c_nxt         = c_r;
    p_nxt         = p_r;
    w_nxt         = w_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    delta_nxt     = delta_r;
    depth_a_nxt   = depth_a_r;
    dist_a_nxt    = dist_a_r;
    sum_nxt       = sum_r;
    l_nxt         = l_r;
    l_none_nxt    = l_none_r;
    pend_nxt      = pend_r;
    have_nxt      = have_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_anc_nxt   = out_anc_r;
    out_dist_nxt  = out_dist_r;

    info_we = 1'b0;
    info_wa = c_r[AW-1:0];
    info_wd = '0;
    info_re = 1'b0;
    info_ra = a_r[AW-1:0];
    anc_we  = 1'b0;
    anc_wa  = anc_addr(lvl_r, c_r);
    anc_wd  = NONE;
    anc_rea = 1'b0;
    anc_raa = anc_addr(lvl_r, a_r[ID_W-1:0]);
    anc_reb = 1'b0;
    anc_rab = anc_addr(lvl_r, b_r[ID_W-1:0]);

    unique case (state_r)
      tlca_pkg::S_IDLE: begin
        if (in_valid) begin
          c_nxt = in_node_id;
          p_nxt = in_parent_id;
          w_nxt = in_edge_weight;
          a_nxt = {1'b0, in_query_a};
          b_nxt = {1'b0, in_query_b};
          lvl_nxt = '0;
          if (in_opcode == tlca_pkg::OP_QUERY) begin
            if (qa_ok && qb_ok) state_nxt = tlca_pkg::S_Q_A;
          end else if (c_ok) begin
            if (in_is_root) state_nxt = tlca_pkg::S_LD_ROOT;
            else if (p_ok) state_nxt = tlca_pkg::S_LD_PAR;
          end
        end
      end
      tlca_pkg::S_LD_ROOT: begin
        anc_we = 1'b1;
        anc_wd = NONE;
        if (lvl_r == '0) info_we = 1'b1;
        if (lvl_r == LVL_LAST) state_nxt = tlca_pkg::S_IDLE;
        else lvl_nxt = lvl_r + LW'(1);
      end
      tlca_pkg::S_LD_PAR: begin
        info_re = 1'b1;
        info_ra = p_r[AW-1:0];
        anc_we  = 1'b1;
        anc_wa  = anc_addr('0, c_r);
        anc_wd  = {1'b0, p_r};
        anc_rea = (LIFT_LEVELS > 1);
        anc_raa = anc_addr('0, p_r);
        pend_nxt = (LIFT_LEVELS > 1);
        lvl_nxt = LVL_FIRST;
        state_nxt = tlca_pkg::S_LD_CHAIN;
      end
      tlca_pkg::S_LD_CHAIN: begin
        if (lvl_r == LVL_FIRST) begin
          info_we = 1'b1;
          info_wd[INFO_W-1:DIST_W] = (par_depth == tlca_pkg::DEPTH_MAX) ?
                                     tlca_pkg::DEPTH_MAX : par_depth + DEPTH_W'(1);
          info_wd[DIST_W-1:0] = grown[PATH_W-1] ? tlca_pkg::DIST_MAX : grown[DIST_W-1:0];
        end
        if (LIFT_LEVELS > 1) begin
          anc_we  = 1'b1;
          anc_wd  = nv;
          anc_rea = (lvl_r != LVL_LAST) && (nv != NONE);
          anc_raa = anc_addr(lvl_r, nv[ID_W-1:0]);
          pend_nxt = anc_rea;
        end
        if ((LIFT_LEVELS == 1) || (lvl_r == LVL_LAST)) state_nxt = tlca_pkg::S_IDLE;
        else lvl_nxt = lvl_r + LW'(1);
      end
      tlca_pkg::S_Q_A: begin
        info_re = 1'b1;
        info_ra = a_r[AW-1:0];
        state_nxt = tlca_pkg::S_Q_B;
      end
      tlca_pkg::S_Q_B: begin
        info_re = 1'b1;
        info_ra = b_r[AW-1:0];
        depth_a_nxt = info_q_r[INFO_W-1:DIST_W];
        dist_a_nxt  = info_q_r[DIST_W-1:0];
        state_nxt = tlca_pkg::S_Q_SORT;
      end
      tlca_pkg::S_Q_SORT: begin
        sum_nxt = {1'b0, dist_a_r} + {1'b0, q_dist_b};
        lvl_nxt = '0;
        pend_nxt = 1'b0;
        if (q_da > q_db) begin
          a_nxt = b_r;
          b_nxt = a_r;
          delta_nxt = q_da - q_db;
        end else begin
          delta_nxt = q_db - q_da;
        end
        if (a_r == b_r) begin
          l_nxt = a_r[ID_W-1:0];
          l_none_nxt = 1'b0;
          state_nxt = tlca_pkg::S_Q_INFO;
        end else begin
          state_nxt = tlca_pkg::S_Q_LIFT;
        end
      end
      tlca_pkg::S_Q_LIFT: begin
        anc_reb = delta_r[0] && (bval != NONE);
        anc_rab = anc_addr(lvl_r, bval[ID_W-1:0]);
        pend_nxt = anc_reb;
        b_nxt = bval;
        delta_nxt = delta_r >> 1;
        if (lvl_r == LVL_LAST) state_nxt = tlca_pkg::S_Q_LIFT_END;
        else lvl_nxt = lvl_r + LW'(1);
      end
      tlca_pkg::S_Q_LIFT_END: begin
        if (a_r == bval) begin
          l_nxt = a_r[ID_W-1:0];
          l_none_nxt = 1'b0;
          state_nxt = tlca_pkg::S_Q_INFO;
        end else begin
          b_nxt = bval;
          lvl_nxt = LVL_LAST;
          have_nxt = 1'b0;
          state_nxt = tlca_pkg::S_Q_CLIMB;
        end
      end
      tlca_pkg::S_Q_CLIMB: begin
        anc_rea = 1'b1;
        anc_raa = anc_addr(lvl_r, a_cl[ID_W-1:0]);
        anc_reb = 1'b1;
        anc_rab = anc_addr(lvl_r, b_cl[ID_W-1:0]);
        a_nxt = a_cl;
        b_nxt = b_cl;
        have_nxt = 1'b1;
        if (lvl_r == '0) state_nxt = tlca_pkg::S_Q_CLIMB_END;
        else lvl_nxt = lvl_r - LW'(1);
      end
      tlca_pkg::S_Q_CLIMB_END: begin
        anc_rea = 1'b1;
        anc_raa = anc_addr('0, a_cl[ID_W-1:0]);
        a_nxt = a_cl;
        b_nxt = b_cl;
        state_nxt = tlca_pkg::S_Q_LCA;
      end
      tlca_pkg::S_Q_LCA: begin
        l_nxt = lca[ID_W-1:0];
        l_none_nxt = (lca == NONE);
        state_nxt = tlca_pkg::S_Q_INFO;
      end
      tlca_pkg::S_Q_INFO: begin
        info_re = 1'b1;
        info_ra = l_r[AW-1:0];
        state_nxt = tlca_pkg::S_Q_OUT;
      end
      tlca_pkg::S_Q_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (l_none_r) begin
            out_anc_nxt  = '0;
            out_dist_nxt = sum_r;
          end else begin
            out_anc_nxt  = l_r;
            out_dist_nxt = (sub2 > sum_r) ? '0 : sum_r - sub2;
          end
          state_nxt = tlca_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tlca_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_wa] <= info_wd;
    if (info_re) info_q_r <= info_mem[info_ra];
  end

  always_ff @(posedge clk) begin
    if (anc_we) anc_mem[anc_wa] <= anc_wd;
    if (anc_rea) anc_qa_r <= anc_mem[anc_raa];
    if (anc_reb) anc_qb_r <= anc_mem[anc_rab];
    if (anc_rea) fwd_d_r <= anc_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlca_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      have_r      <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      have_r      <= have_nxt;
      fwd_r       <= anc_rea && anc_we && (anc_wa == anc_raa);
    end
  end

  always_ff @(posedge clk) begin
    lvl_r      <= lvl_nxt;
    c_r        <= c_nxt;
    p_r        <= p_nxt;
    w_r        <= w_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    delta_r    <= delta_nxt;
    depth_a_r  <= depth_a_nxt;
    dist_a_r   <= dist_a_nxt;
    sum_r      <= sum_nxt;
    l_r        <= l_nxt;
    l_none_r   <= l_none_nxt;
    out_anc_r  <= out_anc_nxt;
    out_dist_r <= out_dist_nxt;
  end

  a_beat_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == tlca_pkg::S_Q_OUT))
    else $error("result beat raised outside the query output step");

  a_write_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    anc_we |-> (state_r == tlca_pkg::S_LD_ROOT || state_r == tlca_pkg::S_LD_PAR ||
                state_r == tlca_pkg::S_LD_CHAIN))
    else $error("ancestor table written outside a load");

  a_fwd_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> $past(state_r == tlca_pkg::S_LD_PAR || state_r == tlca_pkg::S_LD_CHAIN))
    else $error("ancestor forwarding taken outside a load");

endmodule

`default_nettype wire

// ===== bench/lca_answer_checker.sv =====
// Answer checker for the tree LCA distance engine: mirrors depth, root distance and
// ancestor rows from every accepted load beat and compares each result beat.
// Depends on tlca_pkg.
module lca_answer_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [tlca_pkg::ID_W-1:0]   in_node_id,
  input  logic [tlca_pkg::ID_W-1:0]   in_parent_id,
  input  logic                        in_is_root,
  input  logic [tlca_pkg::WGT_W-1:0]  in_edge_weight,
  input  logic [tlca_pkg::ID_W-1:0]   in_query_a,
  input  logic [tlca_pkg::ID_W-1:0]   in_query_b,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [tlca_pkg::ID_W-1:0]   out_ancestor_node,
  input  logic [tlca_pkg::PATH_W-1:0] out_path_distance,
  output int                          errors,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tlca_pkg::*;

  localparam int NODES  = DEF_MAX_NODES;
  localparam int LEVELS = DEF_LIFT_LEVELS;

  typedef struct packed {
    logic [ID_W-1:0]   node;
    logic [PATH_W-1:0] path;
  } answer_t;

  logic [DEPTH_W-1:0] m_depth [NODES];
  logic [DIST_W-1:0]  m_dist  [NODES];
  logic [ANC_W-1:0]   m_anc   [LEVELS][NODES];
  answer_t            answer_q [$];
  int                 fail_count = 0;

  assign errors  = fail_count;
  assign pending = answer_q.size();

  initial begin
    for (int n = 0; n < NODES; n++) begin
      m_depth[n] = '0;
      m_dist[n]  = '0;
      for (int l = 0; l < LEVELS; l++) m_anc[l][n] = '0;
    end
  end

  task automatic report_miss(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic logic [ANC_W-1:0] lift_one(input int lvl, input logic [ANC_W-1:0] n);
    if (n == ANC_NONE || int'(n) >= NODES || lvl >= LEVELS) return ANC_NONE;
    return m_anc[lvl][n[ID_W-1:0]];
  endfunction

  task automatic record_load(input logic [ID_W-1:0] c, input logic [ID_W-1:0] p,
                             input logic root, input logic [WGT_W-1:0] w);
    logic [DEPTH_W-1:0] d;
    logic [DIST_W:0]    s;
    logic [ANC_W-1:0]   prev;
    if (root) begin
      m_depth[c] = '0;
      m_dist[c]  = '0;
      for (int l = 0; l < LEVELS; l++) m_anc[l][c] = ANC_NONE;
      return;
    end
    d = m_depth[p];
    s = {1'b0, m_dist[p]} + (DIST_W+1)'(w);
    m_depth[c] = (d >= DEPTH_MAX) ? DEPTH_MAX : d + 1'b1;
    m_dist[c]  = (s > {1'b0, DIST_MAX}) ? DIST_MAX : s[DIST_W-1:0];
    prev = {1'b0, p};
    m_anc[0][c] = prev;
    for (int l = 1; l < LEVELS; l++) begin
      prev = lift_one(l - 1, prev);
      m_anc[l][c] = prev;
    end
  endtask

  function automatic logic [ANC_W-1:0] meet_node(input logic [ID_W-1:0] qa,
                                                 input logic [ID_W-1:0] qb);
    logic [ANC_W-1:0]   a, b, t, ua, ub;
    logic [DEPTH_W-1:0] delta;
    if (qa == qb) return {1'b0, qa};
    a = {1'b0, qa};
    b = {1'b0, qb};
    if (m_depth[a[ID_W-1:0]] > m_depth[b[ID_W-1:0]]) begin
      t = a;
      a = b;
      b = t;
    end
    delta = m_depth[b[ID_W-1:0]] - m_depth[a[ID_W-1:0]];
    for (int l = 0; l < LEVELS; l++)
      if (l < DEPTH_W && delta[l]) b = lift_one(l, b);
    if (a == b) return a;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      ua = lift_one(l, a);
      ub = lift_one(l, b);
      if (ua != ub) begin
        a = ua;
        b = ub;
      end
    end
    return lift_one(0, a);
  endfunction

  function automatic answer_t predict_answer(input logic [ID_W-1:0] qa,
                                             input logic [ID_W-1:0] qb);
    answer_t           ans;
    logic [PATH_W-1:0] sum, sub;
    logic [ANC_W-1:0]  l;
    sum = PATH_W'(m_dist[qa]) + PATH_W'(m_dist[qb]);
    l = meet_node(qa, qb);
    if (l == ANC_NONE || int'(l) >= NODES) begin
      ans.node = '0;
      ans.path = sum;
    end else begin
      sub = {m_dist[l[ID_W-1:0]], 1'b0};
      ans.node = l[ID_W-1:0];
      ans.path = (sub > sum) ? '0 : sum - sub;
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          report_miss("result beat with none pending", 64'(out_ancestor_node), 64'd0);
        end else begin
          want = answer_q.pop_front();
          if (out_ancestor_node !== want.node)
            report_miss("ancestor_node", 64'(out_ancestor_node), 64'(want.node));
          if (out_path_distance !== want.path)
            report_miss("path_distance", 64'(out_path_distance), 64'(want.path));
        end
      end
      if (in_valid && !in_stall) begin
        if (in_opcode == OP_LOAD)
          record_load(in_node_id, in_parent_id, in_is_root, in_edge_weight);
        else
          answer_q.insert(answer_q.size(), predict_answer(in_query_a, in_query_b));
      end
    end
  end

endmodule

// ===== bench/tree_lca_distance_query_top_test.sv =====
// Top of the tree LCA distance bench: clock, reset, load and query stimulus, stall bursts
// and the verdict. Depends on tlca_pkg, tree_lca_distance_query_top and lca_answer_checker.
module tree_lca_distance_query_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tlca_pkg::*;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic              in_opcode      = OP_LOAD;
  logic [ID_W-1:0]   in_node_id     = '0;
  logic [ID_W-1:0]   in_parent_id   = '0;
  logic              in_is_root     = 1'b0;
  logic [WGT_W-1:0]  in_edge_weight = '0;
  logic [ID_W-1:0]   in_query_a     = '0;
  logic [ID_W-1:0]   in_query_b     = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [ID_W-1:0]   out_ancestor_node;
  logic [PATH_W-1:0] out_path_distance;
  int                errors;
  int                pending;

  bit                idle_on = 1'b1;
  bit                is_loaded [DEF_MAX_NODES];
  int                loaded_ids [$];
  int                last_node;
  int                perm [DEF_MAX_NODES];

  always #5 clk = ~clk;

  tree_lca_distance_query_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_node_id        (in_node_id),
    .in_parent_id      (in_parent_id),
    .in_is_root        (in_is_root),
    .in_edge_weight    (in_edge_weight),
    .in_query_a        (in_query_a),
    .in_query_b        (in_query_b),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ancestor_node (out_ancestor_node),
    .out_path_distance (out_path_distance)
  );

  lca_answer_checker answer_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_node_id        (in_node_id),
    .in_parent_id      (in_parent_id),
    .in_is_root        (in_is_root),
    .in_edge_weight    (in_edge_weight),
    .in_query_a        (in_query_a),
    .in_query_b        (in_query_b),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ancestor_node (out_ancestor_node),
    .out_path_distance (out_path_distance),
    .errors            (errors),
    .pending           (pending)
  );

  task automatic send_beat(input logic op, input logic [ID_W-1:0] node,
                           input logic [ID_W-1:0] parent, input logic root,
                           input logic [WGT_W-1:0] w, input logic [ID_W-1:0] qa,
                           input logic [ID_W-1:0] qb);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_node_id     <= node;
    in_parent_id   <= parent;
    in_is_root     <= root;
    in_edge_weight <= w;
    in_query_a     <= qa;
    in_query_b     <= qb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_node(input int node, input int parent, input bit root,
                           input logic [WGT_W-1:0] w);
    send_beat(OP_LOAD, ID_W'(node), ID_W'(parent), root, w,
              ID_W'($urandom), ID_W'($urandom));
    if (!is_loaded[node]) begin
      is_loaded[node] = 1'b1;
      loaded_ids.insert(loaded_ids.size(), node);
    end
    last_node = node;
  endtask

  task automatic ask(input int qa, input int qb);
    send_beat(OP_QUERY, ID_W'($urandom), ID_W'($urandom), 1'($urandom), $urandom,
              ID_W'(qa), ID_W'(qb));
  endtask

  function automatic logic [WGT_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return WGT_W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_loaded();
    return loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
  endfunction

  // mostly growing trees with queries on loaded nodes; reloads and cycles as noise
  task automatic random_mix(input int count);
    int  node, parent, qa;
    bit  root;
    for (int n = 0; n < count; n++) begin
      if (loaded_ids.size() == 0 || $urandom_range(0, 99) < 45) begin
        root = (loaded_ids.size() == 0) || ($urandom_range(0, 9) == 0);
        node = ($urandom_range(0, 3) == 0 && loaded_ids.size() > 0) ?
               pick_loaded() : $urandom_range(0, DEF_MAX_NODES - 1);
        if (root) parent = $urandom_range(0, DEF_MAX_NODES - 1);
        else if ($urandom_range(0, 1) == 0) parent = last_node;
        else parent = pick_loaded();
        load_node(node, parent, root, pick_weight());
      end else begin
        qa = pick_loaded();
        ask(qa, ($urandom_range(0, 9) == 0) ? qa : pick_loaded());
      end
    end
  endtask

  // one chain through every id, then wrap-around reloads to saturate depth and distance
  task automatic deep_chain();
    int j, t, qa;
    for (int k = 0; k < DEF_MAX_NODES; k++) perm[k] = k;
    for (int k = DEF_MAX_NODES - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = perm[k];
      perm[k] = perm[j];
      perm[j] = t;
    end
    load_node(perm[0], $urandom_range(0, DEF_MAX_NODES - 1), 1'b1, $urandom);
    for (int k = 1; k < DEF_MAX_NODES; k++)
      load_node(perm[k], perm[k-1], 1'b0, ($urandom_range(0, 31) == 0) ? $urandom : '1);
    for (int k = 0; k < 40; k++)
      load_node(perm[k], perm[(k + DEF_MAX_NODES - 1) % DEF_MAX_NODES], 1'b0, '1);
    for (int n = 0; n < 60; n++) begin
      case ($urandom_range(0, 3))
        0: ask(perm[DEF_MAX_NODES-1], perm[$urandom_range(0, DEF_MAX_NODES - 1)]);
        1: ask(perm[$urandom_range(0, DEF_MAX_NODES - 1)],
               perm[$urandom_range(0, DEF_MAX_NODES - 1)]);
        2: begin
          qa = perm[$urandom_range(0, DEF_MAX_NODES - 1)];
          ask(qa, qa);
        end
        default: ask(perm[$urandom_range(0, 63)],
                     perm[$urandom_range(DEF_MAX_NODES - 64, DEF_MAX_NODES - 1)]);
      endcase
    end
  endtask

  initial begin
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_node(0, 10'h3FF, 1'b1, '1);
    load_node(1, 0, 1'b0, '1);
    load_node(2, 1, 1'b0, '0);
    load_node(1023, 0, 1'b0, 32'd5);
    load_node(512, 0, 1'b1, '0);
    load_node(513, 512, 1'b0, '1);
    ask(2, 2);
    ask(2, 1023);
    ask(1023, 2);
    ask(0, 0);
    ask(2, 513);
    ask(1, 2);
    ask(0, 1023);
    // lca farther from the root than both queried nodes
    load_node(1, 0, 1'b0, '0);
    load_node(3, 1, 1'b0, '0);
    load_node(4, 1, 1'b0, '0);
    load_node(1, 0, 1'b0, '1);
    ask(3, 4);
    // root reloaded under its own grandchild
    load_node(0, 2, 1'b0, 32'd1);
    ask(0, 1023);
    ask(1023, 513);

    random_mix(120);
    deep_chain();
    idle_on = 1'b0;
    random_mix(80);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
